// File: hw/rtl/necir_pkg.sv
// ----------------------------------------------------------------------------
// necir_pkg
// Types and constants shared by the NEC IR frame decoder modules.
// ----------------------------------------------------------------------------
`default_nettype none

package necir_pkg;

  localparam int unsigned DATA_BITS    = 32;
  localparam int unsigned FRAME_EDGES  = 2 * DATA_BITS + 4;
  localparam int unsigned REPEAT_EDGES = 4;
  localparam int unsigned EDGE_W       = 7;
  localparam int unsigned TIME_W       = 32;
  localparam int unsigned WIN_W        = 28;
  localparam int unsigned TMO_W        = 30;

  typedef enum logic [1:0] {
    KIND_KEY    = 2'd0,
    KIND_REPEAT = 2'd1,
    KIND_ERROR  = 2'd2
  } kind_t;

  typedef enum logic {
    OP_EDGE = 1'b0,
    OP_TICK = 1'b1
  } op_t;

  typedef enum logic [2:0] {
    REG_LEADER_MARK_MIN  = 3'd0,
    REG_LEADER_MARK_MAX  = 3'd1,
    REG_REPEAT_SPACE_MIN = 3'd2,
    REG_REPEAT_SPACE_MAX = 3'd3,
    REG_FRAME_SPACE_MIN  = 3'd4,
    REG_FRAME_SPACE_MAX  = 3'd5,
    REG_ONE_BIT_THRESH   = 3'd6,
    REG_IDLE_TIMEOUT     = 3'd7
  } reg_idx_t;

  localparam logic [WIN_W-1:0] RST_LEADER_MARK_MIN  = 28'd8000000;
  localparam logic [WIN_W-1:0] RST_LEADER_MARK_MAX  = 28'd10000000;
  localparam logic [WIN_W-1:0] RST_REPEAT_SPACE_MIN = 28'd2000000;
  localparam logic [WIN_W-1:0] RST_REPEAT_SPACE_MAX = 28'd2500000;
  localparam logic [WIN_W-1:0] RST_FRAME_SPACE_MIN  = 28'd3500000;
  localparam logic [WIN_W-1:0] RST_FRAME_SPACE_MAX  = 28'd5500000;
  localparam logic [WIN_W-1:0] RST_ONE_BIT_THRESH   = 28'd1000000;
  localparam logic [TMO_W-1:0] RST_IDLE_TIMEOUT     = 30'd100000000;

  typedef struct packed {
    logic [WIN_W-1:0] leader_mark_min;
    logic [WIN_W-1:0] leader_mark_max;
    logic [WIN_W-1:0] repeat_space_min;
    logic [WIN_W-1:0] repeat_space_max;
    logic [WIN_W-1:0] frame_space_min;
    logic [WIN_W-1:0] frame_space_max;
    logic [WIN_W-1:0] one_bit_threshold;
    logic [TMO_W-1:0] idle_timeout;
  } cfg_t;

  // classified item held in the queue between front and back
  typedef struct packed {
    op_t               op;
    logic [TIME_W-1:0] now_ns;
  } item_t;

endpackage

`default_nettype wire

// File: hw/rtl/necir_front.sv
// ----------------------------------------------------------------------------
// necir_front
// Accepts input items, classifies them and holds them in a two-entry queue.
// ----------------------------------------------------------------------------
`default_nettype none

module necir_front (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         s_tvalid,
  output logic                              s_tready,
  input  wire logic [31:0]                  s_tdata,   // [31:0] now_ns
  input  wire logic                         s_tuser,   // [0] opcode
  output logic                              q_valid,
  input  wire logic                         q_pop,
  output necir_pkg::item_t                  q_item
);

  necir_pkg::item_t entries [2];
  logic             wr_ptr;
  logic             rd_ptr;
  logic [1:0]       count;
  logic             push;
  necir_pkg::item_t in_item;

  always_comb begin
    in_item.op     = s_tuser ? necir_pkg::OP_TICK : necir_pkg::OP_EDGE;
    in_item.now_ns = s_tdata;
  end

  assign s_tready = (count != 2'd2);
  assign q_valid  = (count != 2'd0);
  assign push     = s_tvalid && s_tready;
  assign q_item   = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= in_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (q_pop) begin
        rd_ptr <= ~rd_ptr;
      end
      case ({push, q_pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/necir_back.sv
// ----------------------------------------------------------------------------
// necir_back
// Frame decoder state and output register; pops one item a cycle unless output is stalled.
// ----------------------------------------------------------------------------
`default_nettype none

module necir_back (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire necir_pkg::cfg_t      cfg,
  input  wire logic                 q_valid,
  output logic                      q_pop,
  input  wire necir_pkg::item_t     q_item,
  output logic                      m_tvalid,
  input  wire logic                 m_tready,
  output logic [15:0]               m_tdata,   // [7:0] address_byte, [15:8] command_byte
  output logic [1:0]                m_tuser    // [1:0] result_kind
);

  localparam int unsigned EW = necir_pkg::EDGE_W;
  localparam int unsigned TW = necir_pkg::TIME_W;

  logic [EW-1:0]    edge_count, edge_count_next;
  logic [TW-1:0]    last_edge_time, last_edge_time_next;
  logic             leader_mark_good, leader_mark_good_next;
  logic             repeat_space_good, repeat_space_good_next;
  logic             frame_space_good, frame_space_good_next;
  logic [TW-1:0]    data_shift, data_shift_next;
  logic             timer_armed, timer_armed_next;

  logic             emit;
  necir_pkg::kind_t emit_kind;
  logic [7:0]       emit_addr;
  logic [7:0]       emit_cmd;

  logic [TW-1:0]    delta;
  logic             win_mark, win_rep, win_frame, bit_one, expired;
  logic             ok;
  logic [7:0]       b0, b1, b2, b3;

  assign q_pop = q_valid && (!m_tvalid || m_tready);
  assign delta = q_item.now_ns - last_edge_time;

  always_comb begin
    win_mark  = (delta >= TW'(cfg.leader_mark_min)) && (delta <= TW'(cfg.leader_mark_max));
    win_rep   = (delta >= TW'(cfg.repeat_space_min)) && (delta <= TW'(cfg.repeat_space_max));
    win_frame = (delta >= TW'(cfg.frame_space_min)) && (delta <= TW'(cfg.frame_space_max));
    bit_one   = (delta > TW'(cfg.one_bit_threshold));
    expired   = (delta >= TW'(cfg.idle_timeout));
  end

  always_comb begin
    edge_count_next        = edge_count;
    last_edge_time_next    = last_edge_time;
    leader_mark_good_next  = leader_mark_good;
    repeat_space_good_next = repeat_space_good;
    frame_space_good_next  = frame_space_good;
    data_shift_next        = data_shift;
    timer_armed_next       = timer_armed;
    emit      = 1'b0;
    emit_kind = necir_pkg::KIND_ERROR;
    emit_addr = 8'd0;
    emit_cmd  = 8'd0;
    ok        = 1'b0;
    b0 = 8'd0;
    b1 = 8'd0;
    b2 = 8'd0;
    b3 = 8'd0;

    if (q_pop) begin
      unique case (q_item.op)
        necir_pkg::OP_TICK: begin
          if (timer_armed && expired) begin
            edge_count_next        = '0;
            leader_mark_good_next  = 1'b0;
            repeat_space_good_next = 1'b0;
            frame_space_good_next  = 1'b0;
            data_shift_next        = '0;
            timer_armed_next       = 1'b0;
            emit      = 1'b1;
            emit_kind = necir_pkg::KIND_ERROR;
          end
        end
        default: begin
          if (edge_count == EW'(1)) begin
            leader_mark_good_next = win_mark;
          end else if (edge_count == EW'(2)) begin
            repeat_space_good_next = win_rep;
            frame_space_good_next  = win_frame;
          end else if (edge_count >= EW'(necir_pkg::REPEAT_EDGES) &&
                       edge_count <= EW'(necir_pkg::FRAME_EDGES - 2) && !edge_count[0]) begin
            data_shift_next = {data_shift[TW-2:0], bit_one};
          end
          last_edge_time_next = q_item.now_ns;

          b0 = data_shift_next[31:24];
          b1 = data_shift_next[23:16];
          b2 = data_shift_next[15:8];
          b3 = data_shift_next[7:0];
          ok = leader_mark_good_next && frame_space_good_next &&
               (b0 == ~b1) && (b2 == ~b3);

          if ((edge_count == EW'(necir_pkg::REPEAT_EDGES - 1)) &&
              leader_mark_good_next && repeat_space_good_next) begin
            emit      = 1'b1;
            emit_kind = necir_pkg::KIND_REPEAT;
          end else if (edge_count >= EW'(necir_pkg::FRAME_EDGES - 1)) begin
            emit = 1'b1;
            if (ok) begin
              emit_kind = necir_pkg::KIND_KEY;
              emit_addr = b0;
              emit_cmd  = b2;
            end else begin
              emit_kind = necir_pkg::KIND_ERROR;
            end
          end

          if (emit) begin
            edge_count_next        = '0;
            leader_mark_good_next  = 1'b0;
            repeat_space_good_next = 1'b0;
            frame_space_good_next  = 1'b0;
            data_shift_next        = '0;
            timer_armed_next       = 1'b0;
          end else begin
            edge_count_next  = edge_count + EW'(1);
            timer_armed_next = 1'b1;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      edge_count        <= '0;
      last_edge_time    <= '0;
      leader_mark_good  <= 1'b0;
      repeat_space_good <= 1'b0;
      frame_space_good  <= 1'b0;
      data_shift        <= '0;
      timer_armed       <= 1'b0;
      m_tvalid          <= 1'b0;
    end else begin
      edge_count        <= edge_count_next;
      last_edge_time    <= last_edge_time_next;
      leader_mark_good  <= leader_mark_good_next;
      repeat_space_good <= repeat_space_good_next;
      frame_space_good  <= frame_space_good_next;
      data_shift        <= data_shift_next;
      timer_armed       <= timer_armed_next;
      if (emit) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      m_tuser <= emit_kind;
      m_tdata <= {emit_cmd, emit_addr};
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/nec_ir_frame_decoder.sv
// ----------------------------------------------------------------------------
// nec_ir_frame_decoder
// NEC infrared frame decoder working on timestamped receiver pin edges.
// ----------------------------------------------------------------------------
// Input items arrive on s_*: s_tuser is the opcode (0 pin edge, 1 timer tick),
// s_tdata the 32-bit nanosecond timestamp. Results leave on m_*: m_tuser is
// the kind (0 key, 1 repeat, 2 error or timeout), m_tdata holds the address
// byte (low) and command byte (high), both zero unless the kind is key.
// Window limits, bit threshold and idle timeout sit in eight APB registers at
// byte addresses 0..28; write them only while the block is idle.
// An item enters a two-entry queue and the decoder takes one item per cycle
// from it while the output register is free or taken, so the block sustains
// one item per cycle then; the rate is set by the combinational decoder step
// (one subtract, window compares, bit shift), whose result is registered.
// When m_tready is low the output register holds its item, the decoder stops
// and the queue fills; s_tready drops once both entries are taken.
// Reset (rst, synchronous) empties the queue and output, clears the frame
// state and loads the default register values.
// ----------------------------------------------------------------------------
`default_nettype none

module nec_ir_frame_decoder (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [31:0] s_tdata,   // [31:0] now_ns
  input  wire logic        s_tuser,   // [0] opcode
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [15:0]      m_tdata,   // [7:0] address_byte, [15:8] command_byte
  output logic [1:0]       m_tuser,   // [1:0] result_kind
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [4:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  necir_pkg::cfg_t     cfg;
  necir_pkg::reg_idx_t reg_idx;
  logic                cfg_wr;
  logic                q_valid;
  logic                q_pop;
  necir_pkg::item_t    q_item;

  assign pready  = 1'b1;
  assign reg_idx = necir_pkg::reg_idx_t'(paddr[4:2]);
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.leader_mark_min   <= necir_pkg::RST_LEADER_MARK_MIN;
      cfg.leader_mark_max   <= necir_pkg::RST_LEADER_MARK_MAX;
      cfg.repeat_space_min  <= necir_pkg::RST_REPEAT_SPACE_MIN;
      cfg.repeat_space_max  <= necir_pkg::RST_REPEAT_SPACE_MAX;
      cfg.frame_space_min   <= necir_pkg::RST_FRAME_SPACE_MIN;
      cfg.frame_space_max   <= necir_pkg::RST_FRAME_SPACE_MAX;
      cfg.one_bit_threshold <= necir_pkg::RST_ONE_BIT_THRESH;
      cfg.idle_timeout      <= necir_pkg::RST_IDLE_TIMEOUT;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        necir_pkg::REG_LEADER_MARK_MIN:  cfg.leader_mark_min   <= pwdata[27:0];
        necir_pkg::REG_LEADER_MARK_MAX:  cfg.leader_mark_max   <= pwdata[27:0];
        necir_pkg::REG_REPEAT_SPACE_MIN: cfg.repeat_space_min  <= pwdata[27:0];
        necir_pkg::REG_REPEAT_SPACE_MAX: cfg.repeat_space_max  <= pwdata[27:0];
        necir_pkg::REG_FRAME_SPACE_MIN:  cfg.frame_space_min   <= pwdata[27:0];
        necir_pkg::REG_FRAME_SPACE_MAX:  cfg.frame_space_max   <= pwdata[27:0];
        necir_pkg::REG_ONE_BIT_THRESH:   cfg.one_bit_threshold <= pwdata[27:0];
        necir_pkg::REG_IDLE_TIMEOUT:     cfg.idle_timeout      <= pwdata[29:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      necir_pkg::REG_LEADER_MARK_MIN:  prdata = {4'd0, cfg.leader_mark_min};
      necir_pkg::REG_LEADER_MARK_MAX:  prdata = {4'd0, cfg.leader_mark_max};
      necir_pkg::REG_REPEAT_SPACE_MIN: prdata = {4'd0, cfg.repeat_space_min};
      necir_pkg::REG_REPEAT_SPACE_MAX: prdata = {4'd0, cfg.repeat_space_max};
      necir_pkg::REG_FRAME_SPACE_MIN:  prdata = {4'd0, cfg.frame_space_min};
      necir_pkg::REG_FRAME_SPACE_MAX:  prdata = {4'd0, cfg.frame_space_max};
      necir_pkg::REG_ONE_BIT_THRESH:   prdata = {4'd0, cfg.one_bit_threshold};
      necir_pkg::REG_IDLE_TIMEOUT:     prdata = {2'd0, cfg.idle_timeout};
      default:                         prdata = 32'd0;
    endcase
  end

  necir_front u_front (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .q_valid  (q_valid),
    .q_pop    (q_pop),
    .q_item   (q_item)
  );

  necir_back u_back (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .q_valid  (q_valid),
    .q_pop    (q_pop),
    .q_item   (q_item),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

endmodule

`default_nettype wire
